// File: rtl/sra_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI response aligner package
// Shared constants, types and helper functions of the response aligner.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int MAX_RESPONSE_BYTES = 16;
    localparam int LEN_W   = 5;
    localparam int WAIT_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 3;
    localparam int ADDR_W  = 3;
    localparam int APB_W   = 32;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [BYTE_W-1:0] IDLE_BYTE    = 8'hFF;
    localparam logic [LEN_W-1:0]  LEN_RESET    = 5'd1;
    localparam logic [WAIT_W-1:0] WAIT_RESET   = 8'd8;
    localparam logic [POS_W-1:0]  POS_ALIGNED  = 3'd7;

    localparam logic REG_RESP_LEN   = 1'b0;
    localparam logic REG_WAIT_LIMIT = 1'b1;

    // one word from the front to the back
    typedef struct packed {
        logic [BYTE_W-1:0] held;
        logic [BYTE_W-1:0] rx;
        logic [POS_W-1:0]  pos;
        logic              last;
        logic              tmo;
    } t_sra_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_sra_qstat;

    function automatic logic [POS_W-1:0] highest_zero(input logic [BYTE_W-1:0] b);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            if (!b[k]) begin
                pos = POS_W'(k);
            end
        end
        return pos;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (int'(len) > MAX_RESPONSE_BYTES) begin
            res = LEN_W'(MAX_RESPONSE_BYTES);
        end
        return res;
    endfunction

endpackage

// File: rtl/sra_if.sv
// ----------------------------------------------------------------------------
// SD SPI response aligner channels
// Valid/ready interfaces for received bytes and aligned response words.
// ----------------------------------------------------------------------------
interface sra_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       arm;

    modport source (output valid, output rx_byte, output arm, input ready);
    modport sink   (input valid, input rx_byte, input arm, output ready);
endinterface

interface sra_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    logic       timed_out;

    modport source (output valid, output data_byte, output last, output timed_out,
                    input ready);
    modport sink   (input valid, input data_byte, input last, input timed_out,
                    output ready);
endinterface

// File: rtl/sra_front.sv
// ----------------------------------------------------------------------------
// SD SPI response aligner front end
// Hunts for the response start, tracks alignment and byte count, and pushes
// one command word per result into the queue.
// ----------------------------------------------------------------------------
module sra_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [sra_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                      i_arm,
    input  logic                      i_q_full,
    input  logic [sra_pkg::LEN_W-1:0]  i_resp_len,
    input  logic [sra_pkg::WAIT_W-1:0] i_wait_limit,
    output logic                      o_ready,
    output logic                      o_push,
    output sra_pkg::t_sra_cmd         o_cmd
);
    import sra_pkg::*;

    typedef enum logic [2:0] {
        PH_DONE   = 3'b001,
        PH_HUNT   = 3'b010,
        PH_STREAM = 3'b100
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [WAIT_W-1:0]  r_wait_cnt, n_wait_cnt;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [BYTE_W-1:0]  r_held, n_held;
    logic [LEN_W-1:0]   r_left, n_left;

    logic               acc;
    logic               hunting;
    logic [WAIT_W-1:0]  wc;
    logic [POS_W-1:0]   hz;
    logic [LEN_W-1:0]   len;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;
    assign hunting = i_arm || (r_phase == PH_HUNT);
    assign wc      = i_arm ? '0 : r_wait_cnt;
    assign hz      = highest_zero(i_rx_byte);
    assign len     = clamp_len(i_resp_len);

    always_comb begin
        n_phase    = r_phase;
        n_wait_cnt = r_wait_cnt;
        n_pos      = r_pos;
        n_held     = r_held;
        n_left     = r_left;
        o_push     = 1'b0;
        o_cmd      = '{held: r_held, rx: i_rx_byte, pos: r_pos, last: 1'b0, tmo: 1'b0};
        if (acc) begin
            if (hunting) begin
                n_wait_cnt = wc;
                if (i_rx_byte == IDLE_BYTE) begin
                    if (wc >= i_wait_limit) begin
                        n_phase    = PH_DONE;
                        o_push     = 1'b1;
                        o_cmd.last = 1'b1;
                        o_cmd.tmo  = 1'b1;
                    end else begin
                        n_phase    = PH_HUNT;
                        n_wait_cnt = wc + 1'b1;
                    end
                end else begin
                    n_pos = hz;
                    if (hz == POS_ALIGNED) begin
                        n_left     = len - 1'b1;
                        o_push     = 1'b1;
                        o_cmd.pos  = hz;
                        o_cmd.last = (len == LEN_W'(1));
                        n_phase    = o_cmd.last ? PH_DONE : PH_STREAM;
                    end else begin
                        n_held  = i_rx_byte;
                        n_left  = len;
                        n_phase = PH_STREAM;
                    end
                end
            end else if (r_phase == PH_STREAM) begin
                o_push     = 1'b1;
                o_cmd.last = (r_left == LEN_W'(1));
                n_left     = r_left - 1'b1;
                if (r_pos != POS_ALIGNED) begin
                    n_held = i_rx_byte;
                end
                if (o_cmd.last) begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_DONE;
            r_wait_cnt <= '0;
            r_pos      <= '0;
            r_held     <= '0;
            r_left     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_wait_cnt <= n_wait_cnt;
            r_pos      <= n_pos;
            r_held     <= n_held;
            r_left     <= n_left;
        end
    end

endmodule

// File: rtl/sra_queue.sv
// ----------------------------------------------------------------------------
// SD SPI response aligner command queue
// Small FIFO that decouples the front end from the output stage.
// ----------------------------------------------------------------------------
module sra_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sra_pkg::t_sra_cmd  i_cmd,
    input  logic               i_pop,
    output sra_pkg::t_sra_cmd  o_cmd,
    output sra_pkg::t_sra_qstat o_stat
);
    import sra_pkg::*;

    t_sra_cmd        r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

// File: rtl/sra_back.sv
// ----------------------------------------------------------------------------
// SD SPI response aligner back end
// Merges adjacent bytes by the start-bit position and drives the output
// register of the result channel.
// ----------------------------------------------------------------------------
module sra_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sra_pkg::t_sra_cmd  i_cmd,
    input  sra_pkg::t_sra_qstat i_qstat,
    output logic               o_pop,
    sra_out_if.source          o_out
);
    import sra_pkg::*;

    logic [BYTE_W-1:0]   val;
    logic [2*BYTE_W-1:0] pair;
    logic                r_valid;
    logic [BYTE_W-1:0]   r_data;
    logic                r_last;
    logic                r_tmo;

    assign pair  = {i_cmd.held, i_cmd.rx} >> ({1'b0, i_cmd.pos} + 4'd1);
    assign o_pop = !i_qstat.empty && (!r_valid || o_out.ready);

    always_comb begin
        if (i_cmd.tmo) begin
            val = '0;
        end else if (i_cmd.pos == POS_ALIGNED) begin
            val = i_cmd.rx;
        end else begin
            val = pair[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= val;
            r_last <= i_cmd.last;
            r_tmo  <= i_cmd.tmo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.data_byte = r_data;
    assign o_out.last      = r_last;
    assign o_out.timed_out = r_tmo;

endmodule

// File: rtl/sd_spi_response_aligner_unit.sv
// ----------------------------------------------------------------------------
// SD SPI response aligner
// Turns received SPI bytes into the card's byte-aligned response.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries received bytes; arm=1 marks the first byte after a command
//   and restarts the hunt. o_out carries aligned response words, MSB first,
//   with last on the final word; a missed response gives one word with
//   timed_out=1, last=1 and data 0.
//   The APB port holds response_length (0x0) and wait_limit (0x4); write
//   them only while the block is idle.
// Timing:
//   One byte per cycle sustained while o_out does not stall. A result word
//   reaches o_out through front end -> queue -> output register.
//   An unaligned response gives its first word with its second byte.
// Reset / stall:
//   Reset empties the queue, clears the output and leaves the block ignoring
//   bytes until armed. When o_out stalls, the 4-word queue fills and then
//   i_in.ready drops until a word is taken.
// ----------------------------------------------------------------------------
module sd_spi_response_aligner_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sra_in_if.sink                      i_in,
    sra_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sra_pkg::ADDR_W-1:0]  paddr,
    input  logic [sra_pkg::APB_W-1:0]   pwdata,
    output logic [sra_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);
    import sra_pkg::*;

    logic [LEN_W-1:0]  r_resp_len;
    logic [WAIT_W-1:0] r_wait_limit;
    logic              wr_en;
    logic              push, pop;
    t_sra_cmd          push_cmd, head_cmd;
    t_sra_qstat        qstat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_len   <= LEN_RESET;
            r_wait_limit <= WAIT_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_RESP_LEN:   r_resp_len   <= pwdata[LEN_W-1:0];
                REG_WAIT_LIMIT: r_wait_limit <= pwdata[WAIT_W-1:0];
                default:        r_resp_len   <= r_resp_len;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RESP_LEN:   prdata = APB_W'(r_resp_len);
            REG_WAIT_LIMIT: prdata = APB_W'(r_wait_limit);
            default:        prdata = '0;
        endcase
    end

    sra_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_rx_byte   (i_in.rx_byte),
        .i_arm       (i_in.arm),
        .i_q_full    (qstat.full),
        .i_resp_len  (r_resp_len),
        .i_wait_limit(r_wait_limit),
        .o_ready     (i_in.ready),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    sra_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_cmd  (head_cmd),
        .o_stat (qstat)
    );

    sra_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (head_cmd),
        .i_qstat(qstat),
        .o_pop  (pop),
        .o_out  (o_out)
    );

`ifndef ASSERT_OFF
    a_qstat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty");

    a_tmo_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.timed_out |-> o_out.last && (o_out.data_byte == '0))
        else $error("timeout word malformed");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("push into full queue");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI response aligner testbench
// Feeds received-byte streams (armed hunts, idle runs, aligned and unaligned
// responses, timeouts, aborted responses and noise) through the valid/ready
// input under random gaps and output stalls. A behavioral predictor computes
// each expected response word, which is checked field by field in arrival
// order. Register settings are changed over APB between idle phases.
// ----------------------------------------------------------------------------
module tb;
    import sra_pkg::*;

    localparam int LONG_HOLD   = 200;
    localparam int DRAIN_LIMIT = 50000;
    localparam int ITEM_TARGET = 1400;

    typedef enum logic [2:0] {
        PH_DONE   = 3'b001,
        PH_HUNT   = 3'b010,
        PH_STREAM = 3'b100
    } t_resp_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              arm;
    } t_rx_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              tmo;
    } t_resp_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    sra_in_if  in_if ();
    sra_out_if out_if ();

    sd_spi_response_aligner_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state and register copy
    logic [LEN_W-1:0]  cfg_len    = LEN_RESET;
    logic [WAIT_W-1:0] cfg_wait   = WAIT_RESET;
    t_resp_phase       resp_phase = PH_DONE;
    logic [WAIT_W-1:0] idle_count = '0;
    logic [POS_W-1:0]  start_pos  = '0;
    logic [BYTE_W-1:0] prev_rx    = '0;
    logic [LEN_W-1:0]  bytes_due  = '0;

    t_rx_item   rx_pending[$];
    t_resp_word resp_expected[$];

    int items_made    = 0;
    int mismatch_cnt  = 0;
    bit gaps_on       = 1'b1;
    bit stalls_on     = 1'b1;
    bit long_hold_req = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int resp_len();
        if (cfg_len == '0) return 1;
        if (int'(cfg_len) > MAX_RESPONSE_BYTES) return MAX_RESPONSE_BYTES;
        return int'(cfg_len);
    endfunction

    function automatic logic [POS_W-1:0] msb_zero(input logic [BYTE_W-1:0] b);
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            if (!b[k]) return POS_W'(k);
        end
        return '0;
    endfunction

    function automatic void predict_response(input logic [BYTE_W-1:0] rx, input logic arm);
        t_resp_word w;
        logic       streaming;
        w = '0;
        if (arm) begin
            resp_phase = PH_HUNT;
            idle_count = '0;
        end
        streaming = (resp_phase == PH_STREAM);
        if (resp_phase == PH_HUNT) begin
            if (rx == IDLE_BYTE) begin
                if (idle_count >= cfg_wait) begin
                    resp_phase = PH_DONE;
                    w.last = 1'b1;
                    w.tmo  = 1'b1;
                    resp_expected.push_back(w);
                end else begin
                    idle_count++;
                end
            end else begin
                start_pos  = msb_zero(rx);
                bytes_due  = LEN_W'(resp_len());
                resp_phase = PH_STREAM;
                if (start_pos == POS_ALIGNED) begin
                    streaming = 1'b1;
                end else begin
                    prev_rx = rx;
                end
            end
        end
        if (streaming) begin
            if (start_pos == POS_ALIGNED) begin
                w.data = rx;
            end else begin
                w.data = (prev_rx << (7 - start_pos)) | (rx >> (start_pos + 1));
                prev_rx = rx;
            end
            bytes_due--;
            w.last = (bytes_due == '0);
            if (w.last) resp_phase = PH_DONE;
            resp_expected.push_back(w);
        end
    endfunction

    // stimulus builders
    function automatic void queue_item(input logic [BYTE_W-1:0] b, input logic a);
        t_rx_item it;
        it.rx  = b;
        it.arm = a;
        rx_pending.push_back(it);
        items_made++;
    endfunction

    function automatic logic [BYTE_W-1:0] start_byte(input int p);
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        for (int k = 0; k < BYTE_W; k++) begin
            if (k > p) b[k] = 1'b1;
        end
        b[p] = 1'b0;
        return b;
    endfunction

    function automatic void add_response(input bit broken);
        int n_idle;
        int n_body;
        int p;
        if ($urandom_range(0, 3) == 0) begin
            n_idle = $urandom_range(0, cfg_wait);
        end else begin
            n_idle = $urandom_range(0, (cfg_wait < 3) ? int'(cfg_wait) : 3);
        end
        p = ($urandom_range(0, 2) == 0) ? 7 : $urandom_range(0, 7);
        for (int k = 0; k < n_idle; k++) queue_item(IDLE_BYTE, k == 0);
        queue_item(start_byte(p), n_idle == 0);
        n_body = resp_len() - ((p == 7) ? 1 : 0);
        if (broken && n_body > 0) n_body = $urandom_range(0, n_body - 1);
        repeat (n_body) queue_item(BYTE_W'($urandom), 1'b0);
        if (!broken) begin
            repeat ($urandom_range(0, 2)) queue_item(BYTE_W'($urandom), 1'b0);
        end
    endfunction

    function automatic void add_timeout();
        queue_item(IDLE_BYTE, 1'b1);
        repeat (int'(cfg_wait)) queue_item(IDLE_BYTE, 1'b0);
        if ($urandom_range(0, 1) == 1) queue_item(IDLE_BYTE, 1'b0);
    endfunction

    function automatic void add_noise();
        repeat ($urandom_range(1, 4)) begin
            queue_item(BYTE_W'($urandom), $urandom_range(0, 5) == 0);
        end
    endfunction

    function automatic void add_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            add_response(1'b0);
        end else if (r < 80) begin
            add_response(1'b1);
        end else if (r < 90 && (cfg_wait <= 40 || $urandom_range(0, 7) == 0)) begin
            add_timeout();
        end else begin
            add_noise();
        end
    endfunction

    task automatic apb_write(input logic idx, input logic [APB_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_RESP_LEN) begin
            cfg_len = val[LEN_W-1:0];
        end else begin
            cfg_wait = val[WAIT_W-1:0];
        end
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        while ((rx_pending.size() != 0 || in_if.valid || resp_expected.size() != 0)
               && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        if (resp_expected.size() != 0) begin
            $error("%0d response words never arrived", resp_expected.size());
            mismatch_cnt++;
            resp_expected.delete();
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] len, input logic [WAIT_W-1:0] wlim,
                             input int n_items, input bit hold);
        int stop_at;
        apb_write(REG_RESP_LEN, APB_W'(len));
        apb_write(REG_WAIT_LIMIT, APB_W'(wlim));
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
        if (hold) long_hold_req = 1'b1;
        stop_at = items_made + n_items;
        while (items_made < stop_at) add_sequence();
        wait_drain();
    endtask

    // input driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_rx_item nxt;
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.rx_byte <= '0;
            in_if.arm     <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_response(in_if.rx_byte, in_if.arm);
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (rx_pending.size() != 0) begin
                    nxt = rx_pending.pop_front();
                    in_if.valid   <= 1'b1;
                    in_if.rx_byte <= nxt.rx;
                    in_if.arm     <= nxt.arm;
                    send_gap = gaps_on ? pick_gap() : 0;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // output ready
    int hold_left  = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left  = 0;
            stall_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            stall_left = stalls_on ? pick_gap() : 0;
        end
    end

    // response word checker
    always @(posedge i_clk) begin
        t_resp_word w;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (resp_expected.size() == 0) begin
                $error("unexpected word: data_byte %02h last %0b timed_out %0b",
                       out_if.data_byte, out_if.last, out_if.timed_out);
                mismatch_cnt++;
            end else begin
                w = resp_expected.pop_front();
                if (out_if.data_byte !== w.data) begin
                    $error("data_byte: expected %02h, got %02h", w.data, out_if.data_byte);
                    mismatch_cnt++;
                end
                if (out_if.last !== w.last) begin
                    $error("last: expected %0b, got %0b", w.last, out_if.last);
                    mismatch_cnt++;
                end
                if (out_if.timed_out !== w.tmo) begin
                    $error("timed_out: expected %0b, got %0b", w.tmo, out_if.timed_out);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [LEN_W-1:0]  len;
        logic [WAIT_W-1:0] wlim;
        bit                first_rand;
        in_if.valid   = 1'b0;
        in_if.rx_byte = '0;
        in_if.arm     = 1'b0;
        out_if.ready  = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        first_rand = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings: length 1, wait limit 8
        queue_item(8'h00, 1'b0);                  // ignored while done
        queue_item(8'hFF, 1'b1);                  // idle then aligned start
        queue_item(8'h00, 1'b0);
        queue_item(8'h12, 1'b0);                  // ignored after last
        queue_item(8'hFE, 1'b1);                  // start bit 0, unaligned
        queue_item(8'hA5, 1'b0);
        repeat (9) queue_item(IDLE_BYTE, 1'b0);   // filled below with arm
        rx_pending[rx_pending.size() - 9].arm = 1'b1;
        queue_item(IDLE_BYTE, 1'b0);              // ignored after timeout
        queue_item(8'hBF, 1'b1);                  // start bit 6
        queue_item(8'hFF, 1'b0);
        queue_item(8'hEF, 1'b1);                  // dropped by re-arm
        queue_item(8'h3C, 1'b1);
        queue_item(8'h80, 1'b1);
        queue_item(8'h01, 1'b0);
        queue_item(8'h7F, 1'b1);
        wait_drain();

        // extreme settings
        run_phase(5'd0, 8'd0, 100, 1'b0);
        run_phase(5'd31, 8'd255, 100, 1'b0);
        apb_write(REG_WAIT_LIMIT, APB_W'(8'd255));
        add_timeout();
        wait_drain();
        run_phase(5'd16, 8'd0, 100, 1'b0);
        run_phase(5'd1, 8'd255, 100, 1'b0);
        run_phase(5'd17, 8'd1, 100, 1'b0);

        while (items_made < ITEM_TARGET) begin
            len  = ($urandom_range(0, 2) == 0) ? LEN_W'($urandom_range(0, 31))
                                               : LEN_W'($urandom_range(1, 5));
            wlim = ($urandom_range(0, 4) == 0) ? WAIT_W'($urandom)
                                               : WAIT_W'($urandom_range(0, 12));
            run_phase(len, wlim, 150, first_rand || $urandom_range(0, 5) == 0);
            first_rand = 1'b0;
        end

        wait_drain();
        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/sra_pkg.sv
rtl/sra_if.sv
rtl/sra_front.sv
rtl/sra_queue.sv
rtl/sra_back.sv
rtl/sd_spi_response_aligner_unit.sv
sim/tb.sv
